/* design/mwqd_pkg.sv */
// Shared types, constants and the x4 step decode of the quadrature decoder.
`timescale 1ns / 1ps
package mwqd_pkg;

  localparam int LOGICAL_WHEELS = 4;
  localparam int PIN_W          = 8;
  localparam int MAP_W          = 12;
  localparam int INV_W          = 4;
  localparam int CFG_DATA_W     = 12;
  localparam int IN_TDATA_W     = 16;
  localparam int OUT_TDATA_W    = 104;
  localparam int COUNT_W        = 32;

  typedef enum logic [0:0] {
    CFG_WHEEL_MAP   = 1'b0,
    CFG_INVERT_MASK = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // Controls common to every lane for one accepted word.
  typedef struct packed {
    logic accept;
    logic primed;
    logic tick;
  } lane_ctrl_t;

  // Count state one lane exposes to the report stage.
  typedef struct packed {
    logic [COUNT_W-1:0] position;
    logic [COUNT_W-1:0] window_change;
    logic [COUNT_W-1:0] errors;
  } lane_state_t;

  // Query held for the report stage.
  typedef struct packed {
    logic       valid;
    logic [2:0] phys;
    logic       mapped;
    logic       invert;
  } rep_ctrl_t;

  // x4 quadrature decode: index is {previous A/B, current A/B}.
  function automatic dir_t step_dir(input logic [1:0] prev, input logic [1:0] cur);
    dir_t d;
    unique case ({prev, cur}) inside
      4'd2, 4'd4, 4'd11, 4'd13: d = DIR_UP;
      4'd1, 4'd7, 4'd8, 4'd14:  d = DIR_DOWN;
      default:                  d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage

/* design/mwqd_lane.sv */
// One physical wheel: pin history, position, window and error counters.
`timescale 1ns / 1ps
module mwqd_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mwqd_pkg::lane_ctrl_t ctrl,
  input  logic                 clear,
  input  logic [1:0]           pins,
  output mwqd_pkg::lane_state_t state
);

  logic [1:0]                      prev_r, prev_nxt;
  logic [mwqd_pkg::COUNT_W-1:0]    pos_r, pos_nxt;
  logic [mwqd_pkg::COUNT_W-1:0]    acc_r, acc_nxt;   // position minus window start
  logic [mwqd_pkg::COUNT_W-1:0]    delta_r, delta_nxt;
  logic [mwqd_pkg::COUNT_W-1:0]    err_r, err_nxt;
  mwqd_pkg::dir_t                  dir;

  assign dir = mwqd_pkg::step_dir(prev_r, pins);

  always_comb begin
    prev_nxt  = pins;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    delta_nxt = delta_r;
    err_nxt   = err_r;
    if (ctrl.primed) begin
      case (dir)
        mwqd_pkg::DIR_UP: begin
          pos_nxt = pos_r + 1'b1;
          acc_nxt = acc_r + 1'b1;
        end
        mwqd_pkg::DIR_DOWN: begin
          pos_nxt = pos_r - 1'b1;
          acc_nxt = acc_r - 1'b1;
        end
        default: begin
          if (pins != prev_r && err_r != '1) err_nxt = err_r + 1'b1;
        end
      endcase
    end
    if (ctrl.tick) begin
      delta_nxt = acc_nxt;
      acc_nxt   = '0;
    end
    if (clear) begin
      pos_nxt   = '0;
      acc_nxt   = '0;
      delta_nxt = '0;
      err_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      pos_r   <= '0;
      acc_r   <= '0;
      delta_r <= '0;
      err_r   <= '0;
    end else if (ctrl.accept) begin
      prev_r  <= prev_nxt;
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      delta_r <= delta_nxt;
      err_r   <= err_nxt;
    end
  end

  assign state.position      = pos_r;
  assign state.window_change = delta_r;
  assign state.errors        = err_r;

endmodule

/* design/mwqd_report.sv */
// Merge stage: select the queried lane, apply inversion, hold the result word.
`timescale 1ns / 1ps
module mwqd_report #(
  parameter int WHEELS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mwqd_pkg::rep_ctrl_t                  rep,
  input  mwqd_pkg::lane_state_t                lane_st [WHEELS],
  output logic                                 load_ok,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mwqd_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  mwqd_pkg::lane_state_t                 sel;
  logic [mwqd_pkg::COUNT_W-1:0]          pos, win, err;
  logic                                  out_valid_r, out_valid_nxt;
  logic [mwqd_pkg::OUT_TDATA_W-1:0]      out_data_r, out_data_nxt;

  assign load_ok = !out_valid_r || out_tready;

  always_comb begin
    sel = '0;
    for (int i = 0; i < WHEELS; i++) begin
      if (rep.phys == 3'(i)) sel = lane_st[i];
    end
  end

  always_comb begin
    pos = '0;
    win = '0;
    err = '0;
    if (rep.mapped) begin
      pos = rep.invert ? ('0 - sel.position) : sel.position;
      win = rep.invert ? ('0 - sel.window_change) : sel.window_change;
      err = sel.errors;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load_ok) begin
      out_valid_nxt = rep.valid;
      if (rep.valid) out_data_nxt = {7'd0, rep.mapped, err, win, pos};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/multi_wheel_quadrature_decoder.sv */
// Top level: x4 quadrature decoder for several wheels with logical wheel mapping.
// Throughput: one word per cycle while no report waits behind a held result word;
//   an accepted word updates each lane's counters and the report stage register, and
//   the merge stage then selects the queried wheel into the output register.
// Input stalls only while a report waits behind a result word that is not taken.
// Reset (rst_n low, synchronous) zeroes all counters and pin history, clears primed,
//   loads wheel_map with the identity map and invert_mask with zero.
`timescale 1ns / 1ps
module multi_wheel_quadrature_decoder #(
  parameter int WHEELS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [0:0]                           cfg_index,
  input  logic [mwqd_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Input words.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [7:0] ab_pins, [8] sample_tick, [12:9] clear_mask, [14:13] query_wheel, [15] zero
  input  logic [mwqd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // Result words.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [31:0] position, [63:32] window_change, [95:64] error_transitions,
  // [96] wheel_mapped, [103:97] zero
  output logic [mwqd_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  // Configuration registers.
  logic [mwqd_pkg::MAP_W-1:0]  wheel_map_r, wheel_map_nxt;
  logic [mwqd_pkg::INV_W-1:0]  invert_mask_r, invert_mask_nxt;

  always_comb begin
    wheel_map_nxt   = wheel_map_r;
    invert_mask_nxt = invert_mask_r;
    if (cfg_we) begin
      unique case (mwqd_pkg::cfg_reg_t'(cfg_index))
        mwqd_pkg::CFG_WHEEL_MAP:   wheel_map_nxt   = cfg_data[mwqd_pkg::MAP_W-1:0];
        mwqd_pkg::CFG_INVERT_MASK: invert_mask_nxt = cfg_data[mwqd_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_map_r   <= 12'd1672;
      invert_mask_r <= '0;
    end else begin
      wheel_map_r   <= wheel_map_nxt;
      invert_mask_r <= invert_mask_nxt;
    end
  end

  // Unpack the input word.
  logic [mwqd_pkg::PIN_W-1:0]            ab_pins;
  logic                                  sample_tick;
  logic [mwqd_pkg::LOGICAL_WHEELS-1:0]   clear_mask;
  logic [1:0]                            query_wheel;

  assign ab_pins     = in_tdata[7:0];
  assign sample_tick = in_tdata[8];
  assign clear_mask  = in_tdata[12:9];
  assign query_wheel = in_tdata[14:13];

  // Handshake between the input, the report stage and the output register.
  logic                 in_accept;
  logic                 load_ok;
  mwqd_pkg::rep_ctrl_t  rep_r, rep_nxt;
  logic                 primed_r, primed_nxt;

  assign in_tready = !rep_r.valid || load_ok;
  assign in_accept = in_tvalid && in_tready;

  // Resolve which physical lanes a clear hits; an unmapped logical wheel hits none.
  logic [WHEELS-1:0] clr_phys;

  always_comb begin
    clr_phys = '0;
    for (int p = 0; p < WHEELS; p++) begin
      for (int l = 0; l < mwqd_pkg::LOGICAL_WHEELS; l++) begin
        if (l < WHEELS && clear_mask[l] && wheel_map_r[3*l +: 3] == 3'(p))
          clr_phys[p] = 1'b1;
      end
    end
  end

  // Look up the queried wheel now; the lanes show its updated state next cycle.
  logic [2:0] q_phys;
  logic       q_mapped;

  assign q_phys   = wheel_map_r[3*query_wheel +: 3];
  assign q_mapped = (int'(query_wheel) < WHEELS) && (int'(q_phys) < WHEELS);

  always_comb begin
    primed_nxt = primed_r || in_accept;
    rep_nxt    = rep_r;
    if (in_accept) begin
      rep_nxt.valid  = 1'b1;
      rep_nxt.phys   = q_phys;
      rep_nxt.mapped = q_mapped;
      rep_nxt.invert = invert_mask_r[query_wheel];
    end else if (load_ok) begin
      // Report moves into the output register; drop the stage.
      rep_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r    <= 1'b0;
      rep_r.valid <= 1'b0;
    end else begin
      primed_r    <= primed_nxt;
      rep_r.valid <= rep_nxt.valid;
    end
    rep_r.phys   <= rep_nxt.phys;
    rep_r.mapped <= rep_nxt.mapped;
    rep_r.invert <= rep_nxt.invert;
  end

  // Lanes: one per physical wheel, all advance on every accepted word.
  mwqd_pkg::lane_ctrl_t  lane_ctrl;
  mwqd_pkg::lane_state_t lane_st [WHEELS];

  assign lane_ctrl.accept = in_accept;
  assign lane_ctrl.primed = primed_r;
  assign lane_ctrl.tick   = sample_tick;

  for (genvar g = 0; g < WHEELS; g++) begin : g_lane
    logic [1:0] pins;
    if (2 * g < mwqd_pkg::PIN_W) begin : g_pins
      assign pins = ab_pins[2*g +: 2];
    end else begin : g_nopins
      // Wheels beyond the pin field always read 00.
      assign pins = 2'b00;
    end

    mwqd_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (lane_ctrl),
      .clear (clr_phys[g]),
      .pins  (pins),
      .state (lane_st[g])
    );
  end

  // Merge stage and output register.
  mwqd_report #(
    .WHEELS (WHEELS)
  ) u_report (
    .clk        (clk),
    .rst_n      (rst_n),
    .rep        (rep_r),
    .lane_st    (lane_st),
    .load_ok    (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef NO_ASSERTIONS
  // Input stalls only behind a held result word.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a held result word");

  // Every accepted word reaches the report stage next cycle.
  a_accept_report: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> rep_r.valid)
    else $error("accepted word lost before the report stage");

  // An unmapped report carries zero fields.
  a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[96]) |-> (out_tdata[95:0] == '0))
    else $error("unmapped result with nonzero fields");

  // A report waiting on the output holds lane 0's state still.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rep_r.valid && !load_ok) |=> $stable(lane_st[0]))
    else $error("lane state moved under a waiting report");
`endif

endmodule

/* tb/tb_multi_wheel_quadrature_decoder.sv */
// Self-checking testbench for the multi-wheel x4 quadrature decoder.
`timescale 1ns / 1ps
module tb_multi_wheel_quadrature_decoder;

  localparam int NUM_WHEELS = 4;

  // Expected contents of one result word.
  typedef struct packed {
    logic [mwqd_pkg::COUNT_W-1:0] position;
    logic [mwqd_pkg::COUNT_W-1:0] window_change;
    logic [mwqd_pkg::COUNT_W-1:0] errors;
    logic                         mapped;
  } wheel_report_t;

  // Tracks the count state of every physical wheel and holds the result
  // words still owed by the decoder, oldest first.
  class odometer_board;
    logic [1:0]                   last_pins [NUM_WHEELS];
    bit                           primed;
    logic [mwqd_pkg::COUNT_W-1:0] count     [NUM_WHEELS];
    logic [mwqd_pkg::COUNT_W-1:0] errs      [NUM_WHEELS];
    logic [mwqd_pkg::COUNT_W-1:0] win_start [NUM_WHEELS];
    logic [mwqd_pkg::COUNT_W-1:0] win_delta [NUM_WHEELS];
    logic [mwqd_pkg::MAP_W-1:0]   wheel_map;
    logic [mwqd_pkg::INV_W-1:0]   invert_mask;
    wheel_report_t                expected_reports [$];
    int                           mismatches;
    int                           samples_noted;
    int                           reports_checked;

    function new();
      primed      = 1'b0;
      wheel_map   = 12'd1672;
      invert_mask = '0;
      foreach (count[i]) begin
        last_pins[i] = '0;
        count[i]     = '0;
        errs[i]      = '0;
        win_start[i] = '0;
        win_delta[i] = '0;
      end
    endfunction

    function void set_register(mwqd_pkg::cfg_reg_t idx,
                               logic [mwqd_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        mwqd_pkg::CFG_WHEEL_MAP:   wheel_map   = value[mwqd_pkg::MAP_W-1:0];
        mwqd_pkg::CFG_INVERT_MASK: invert_mask = value[mwqd_pkg::INV_W-1:0];
        default: ;
      endcase
    endfunction

    // Physical wheel behind a logical wheel, -1 when unmapped.
    function int phys_wheel(int logical);
      logic [2:0] p;
      p = wheel_map[3*logical +: 3];
      if (p >= NUM_WHEELS) return -1;
      return int'(p);
    endfunction

    function int step_of(logic [1:0] prev, logic [1:0] cur);
      case ({prev, cur})
        4'b0010, 4'b1011, 4'b1101, 4'b0100: return 1;
        4'b0001, 4'b0111, 4'b1110, 4'b1000: return -1;
        default: return 0;
      endcase
    endfunction

    function void note_sample(logic [mwqd_pkg::IN_TDATA_W-1:0] word);
      logic [7:0]    pins;
      logic          tick;
      logic [3:0]    clr;
      logic [1:0]    q;
      logic [1:0]    cur;
      int            d;
      int            p;
      wheel_report_t r;
      pins = word[7:0];
      tick = word[8];
      clr  = word[12:9];
      q    = word[14:13];
      for (int i = 0; i < NUM_WHEELS; i++) begin
        cur = pins[2*i +: 2];
        if (primed) begin
          d = step_of(last_pins[i], cur);
          if (d > 0) count[i] = count[i] + 1;
          else if (d < 0) count[i] = count[i] - 1;
          else if (cur != last_pins[i] && errs[i] != '1) errs[i] = errs[i] + 1;
        end
        last_pins[i] = cur;
      end
      primed = 1'b1;
      if (tick) begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
          win_delta[i] = count[i] - win_start[i];
          win_start[i] = count[i];
        end
      end
      for (int l = 0; l < mwqd_pkg::LOGICAL_WHEELS; l++) begin
        p = phys_wheel(l);
        if (clr[l] && p >= 0) begin
          count[p]     = '0;
          errs[p]      = '0;
          win_start[p] = '0;
          win_delta[p] = '0;
        end
      end
      p = phys_wheel(q);
      if (p < 0) begin
        r = '0;
      end else begin
        r.position      = invert_mask[q] ? 32'd0 - count[p] : count[p];
        r.window_change = invert_mask[q] ? 32'd0 - win_delta[p] : win_delta[p];
        r.errors        = errs[p];
        r.mapped        = 1'b1;
      end
      expected_reports.push_back(r);
      samples_noted++;
    endfunction

    task flag_mismatch(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      mismatches++;
    endtask

    task check_report(logic [mwqd_pkg::OUT_TDATA_W-1:0] word);
      wheel_report_t e;
      if (expected_reports.size() == 0) begin
        flag_mismatch($sformatf("result word %h with nothing outstanding", word));
        return;
      end
      e = expected_reports.pop_front();
      reports_checked++;
      if (word[31:0] !== e.position)
        flag_mismatch($sformatf("position got %h want %h", word[31:0], e.position));
      if (word[63:32] !== e.window_change)
        flag_mismatch($sformatf("window_change got %h want %h", word[63:32],
                                e.window_change));
      if (word[95:64] !== e.errors)
        flag_mismatch($sformatf("error_transitions got %h want %h", word[95:64], e.errors));
      if (word[96] !== e.mapped)
        flag_mismatch($sformatf("wheel_mapped got %b want %b", word[96], e.mapped));
    endtask
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [0:0]                       cfg_index;
  logic [mwqd_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                             in_tvalid;
  logic                             in_tready;
  // [7:0] ab_pins, [8] sample_tick, [12:9] clear_mask, [14:13] query_wheel, [15] zero
  logic [mwqd_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  // [31:0] position, [63:32] window_change, [95:64] error_transitions,
  // [96] wheel_mapped, [103:97] zero
  logic [mwqd_pkg::OUT_TDATA_W-1:0] out_tdata;

  odometer_board board;
  bit            allow_idle;
  int            settings_used;
  // Last pin pair sent per physical wheel; the random walk steps from here.
  logic [1:0]    walk_pins [NUM_WHEELS];

  multi_wheel_quadrature_decoder #(
    .WHEELS(NUM_WHEELS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run, even with every gap and stall.
  initial begin
    #5_000_000;
    $display("multi_wheel_quadrature_decoder verification failed");
    $finish;
  end

  // Result side: drop tready in random bursts while idling is allowed.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (allow_idle && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Check every result word taken at a rising edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_report(out_tdata);
  end

  // One Gray-code step of an A/B pair: up runs 00 -> 10 -> 11 -> 01 -> 00.
  function automatic logic [1:0] gray_step(logic [1:0] pair, bit up);
    case (pair)
      2'b00:   return up ? 2'b10 : 2'b01;
      2'b10:   return up ? 2'b11 : 2'b00;
      2'b11:   return up ? 2'b01 : 2'b10;
      default: return up ? 2'b00 : 2'b11;
    endcase
  endfunction

  // Offer one input word, maybe after a random gap; hold it until taken.
  task automatic send_sample(input logic [7:0] pins, input logic tick,
                             input logic [3:0] clr, input logic [1:0] q);
    logic [mwqd_pkg::IN_TDATA_W-1:0] word;
    word = {1'b0, q, clr, tick, pins};
    for (int w = 0; w < NUM_WHEELS; w++) walk_pins[w] = pins[2*w +: 2];
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    board.note_sample(word);
    @(negedge clk);
  endtask

  // Mostly clean Gray-code walks on every wheel, with some raw pin noise.
  task automatic random_samples(input int n);
    logic [7:0] pins;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) != 0) begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
          case ($urandom_range(0, 3))
            0:       pins[2*w +: 2] = gray_step(walk_pins[w], 1'b1);
            1:       pins[2*w +: 2] = gray_step(walk_pins[w], 1'b0);
            default: pins[2*w +: 2] = walk_pins[w];
          endcase
        end
      end else begin
        pins = 8'($urandom_range(0, 255));
      end
      send_sample(pins, $urandom_range(0, 5) == 0,
                  ($urandom_range(0, 11) == 0) ? 4'($urandom_range(1, 15)) : 4'd0,
                  2'($urandom_range(0, 3)));
    end
  endtask

  // Hold off new words until every owed result is back and the pipe is empty.
  task automatic drain_reports();
    in_tvalid <= 1'b0;
    while (board.expected_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both registers back to back; we stays high across the two words.
  task automatic apply_settings(input logic [mwqd_pkg::MAP_W-1:0] map,
                                input logic [mwqd_pkg::INV_W-1:0] inv);
    cfg_we    <= 1'b1;
    cfg_index <= mwqd_pkg::CFG_WHEEL_MAP;
    cfg_data  <= map;
    @(posedge clk);
    board.set_register(mwqd_pkg::CFG_WHEEL_MAP, map);
    @(negedge clk);
    cfg_index <= mwqd_pkg::CFG_INVERT_MASK;
    cfg_data  <= mwqd_pkg::CFG_DATA_W'(inv);
    @(posedge clk);
    board.set_register(mwqd_pkg::CFG_INVERT_MASK, mwqd_pkg::CFG_DATA_W'(inv));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input logic [mwqd_pkg::MAP_W-1:0] map,
                           input logic [mwqd_pkg::INV_W-1:0] inv, input int n);
    drain_reports();
    apply_settings(map, inv);
    random_samples(n);
  endtask

  initial begin
    board         = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    allow_idle    = 1'b1;
    settings_used = 1;
    for (int w = 0; w < NUM_WHEELS; w++) walk_pins[w] = 2'b00;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset map (identity) and no inversion.
    // First word only primes the pin history: no step, no error.
    send_sample(8'hFF, 1'b0, 4'h0, 2'd0);
    // Both pins flip on every wheel: an error each.
    send_sample(8'h00, 1'b0, 4'h0, 2'd1);
    // Four steps up on all wheels, tick on the last.
    send_sample(8'hAA, 1'b0, 4'h0, 2'd2);
    send_sample(8'hFF, 1'b0, 4'h0, 2'd3);
    send_sample(8'h55, 1'b0, 4'h0, 2'd0);
    send_sample(8'h00, 1'b1, 4'h0, 2'd1);
    // Four steps down, tick midway.
    send_sample(8'h55, 1'b0, 4'h0, 2'd2);
    send_sample(8'hFF, 1'b1, 4'h0, 2'd3);
    send_sample(8'hAA, 1'b0, 4'h0, 2'd0);
    send_sample(8'h00, 1'b0, 4'h0, 2'd1);
    // Mixed: wheel 0 up, wheel 1 down, wheel 2 double flip, wheel 3 still.
    send_sample(8'h36, 1'b1, 4'h0, 2'd2);
    send_sample(8'h36, 1'b0, 4'h0, 2'd1);
    // Clear one wheel, then all wheels together with a tick and pin changes.
    send_sample(8'h36, 1'b0, 4'h1, 2'd0);
    send_sample(8'h00, 1'b1, 4'hF, 2'd3);
    // Step below zero so the count wraps negative, then latch it.
    send_sample(8'h01, 1'b0, 4'h0, 2'd0);
    send_sample(8'h01, 1'b1, 4'h0, 2'd0);
    random_samples(60);

    // All logical wheels unmapped: zero results, clears ignored.
    run_phase(12'hFFF, 4'hF, 40);
    // Every logical wheel shares physical wheel 2; mixed inversion.
    run_phase(12'h492, 4'h5, 70);
    // Every logical wheel on physical wheel 0, all inverted.
    run_phase(12'h000, 4'hF, 60);
    // Random maps, some entries unmapped.
    repeat (3) run_phase(12'($urandom_range(0, 4095)), 4'($urandom_range(0, 15)), 50);
    // Final stretch at full rate on both sides: permuted map, one unmapped wheel.
    allow_idle = 1'b0;
    run_phase(12'hE19, 4'hA, 80);

    in_tvalid <= 1'b0;
    while (board.expected_reports.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d pin samples across %0d map/inversion settings; checked %0d results.",
             board.samples_noted, settings_used, board.reports_checked);
    $display("Covered priming, invalid flips, clears, shared and unmapped wheels, inversion.");
    if (board.mismatches == 0) begin
      $display("multi_wheel_quadrature_decoder verification clean");
    end else begin
      $display("multi_wheel_quadrature_decoder verification failed");
    end
    $finish;
  end

endmodule
